// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Property must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) not (prop)) \
      else $error("forbidden condition seen");

`endif

// ===== src/pust_pkg.sv =====
package pust_pkg;

   localparam int SLOT_INDEX_W = 6;
   localparam int TICK_W       = 32;

   typedef logic [1:0]              kind_type;
   typedef logic [SLOT_INDEX_W-1:0] slot_type;
   typedef logic [TICK_W-1:0]       tick_type;

   localparam kind_type KIND_UPDATE = 2'd0;
   localparam kind_type KIND_CLEAR  = 2'd1;
   localparam kind_type KIND_READ   = 2'd2;

   localparam tick_type EMPTY_MIN = 32'hFFFF_FFFF;

   typedef struct packed {
      tick_type period_count;
      tick_type missed_periods;
      tick_type cpu_min;
      tick_type cpu_max;
      tick_type cpu_total;
      tick_type wall_min;
      tick_type wall_max;
      tick_type wall_total;
   } stats_rec_type;

   localparam stats_rec_type EMPTY_REC = '{
      period_count:   '0,
      missed_periods: '0,
      cpu_min:        EMPTY_MIN,
      cpu_max:        '0,
      cpu_total:      '0,
      wall_min:       EMPTY_MIN,
      wall_max:       '0,
      wall_total:     '0
   };

endpackage

// ===== src/pust_if.sv =====
interface pust_req_if import pust_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type kind;
   slot_type slot_index;
   logic     period_expired;
   tick_type cpu_ticks;
   tick_type wall_ticks;

   modport source (output valid, kind, slot_index, period_expired, cpu_ticks, wall_ticks,
                   input ready);
   modport sink   (input valid, kind, slot_index, period_expired, cpu_ticks, wall_ticks,
                   output ready);
endinterface

interface pust_rsp_if import pust_pkg::*; ();
   logic     valid;
   logic     ready;
   tick_type period_count;
   tick_type missed_periods;
   tick_type cpu_min;
   tick_type cpu_max;
   tick_type cpu_total;
   tick_type wall_min;
   tick_type wall_max;
   tick_type wall_total;

   modport source (output valid, period_count, missed_periods, cpu_min, cpu_max, cpu_total,
                          wall_min, wall_max, wall_total,
                   input ready);
   modport sink   (input valid, period_count, missed_periods, cpu_min, cpu_max, cpu_total,
                         wall_min, wall_max, wall_total,
                   output ready);
endinterface

// ===== src/pust_ram.sv =====
module pust_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pust_fold.sv =====
module pust_fold import pust_pkg::*; (
   input  stats_rec_type old_rec,
   input  logic          period_expired,
   input  tick_type      cpu_ticks,
   input  tick_type      wall_ticks,
   output stats_rec_type new_rec
);

   always_comb begin
      new_rec.period_count   = old_rec.period_count + 32'd1;
      new_rec.missed_periods = old_rec.missed_periods + {31'd0, period_expired};
      new_rec.cpu_total      = old_rec.cpu_total + cpu_ticks;
      new_rec.wall_total     = old_rec.wall_total + wall_ticks;
      new_rec.cpu_min  = (cpu_ticks  < old_rec.cpu_min)  ? cpu_ticks  : old_rec.cpu_min;
      new_rec.cpu_max  = (cpu_ticks  > old_rec.cpu_max)  ? cpu_ticks  : old_rec.cpu_max;
      new_rec.wall_min = (wall_ticks < old_rec.wall_min) ? wall_ticks : old_rec.wall_min;
      new_rec.wall_max = (wall_ticks > old_rec.wall_max) ? wall_ticks : old_rec.wall_max;
   end

endmodule

// ===== src/period_usage_statistics_table_unit.sv =====
// Per-slot period statistics: count, missed count, min/max/total of cpu and wall ticks.
// req_bus carries one beat per event: kind selects update, clear-all or read; slot_index
// names the slot; an update also brings period_expired, cpu_ticks and wall_ticks.
// rsp_bus returns exactly one beat per request beat, in order: the slot's record after
// the step, or the empty record (minimums all ones, everything else zero) for a clear
// or for a slot at or beyond SLOTS.
// A request beat is registered in the s1 stage; its result is registered in the result
// register when the beat leaves s1. A clear drops all slot valid bits at once.
// Throughput: one beat per cycle while rsp_bus does not stall, set by the single
// read-modify-write of the record RAM; a write still in flight is forwarded to a read
// of the same slot on the next beat, and a clear costs no extra time.
// Reset clears all valid bits and empties the pipeline; the RAM needs no init pass.
// If rsp_bus stalls, the result register holds its beat, the stage behind it holds
// one more, and req_bus.ready drops until the result is taken.
`include "assert_macros.svh"

module period_usage_statistics_table_unit import pust_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   pust_req_if.sink    req_bus,
   pust_rsp_if.source  rsp_bus
);

   localparam int INDEX_SPAN = 1 << SLOT_INDEX_W;
   localparam int USED       = (SLOTS < INDEX_SPAN) ? SLOTS : INDEX_SPAN;
   localparam int AW         = $clog2(USED);

   logic          s1_valid_ff;
   kind_type      s1_kind_ff;
   slot_type      s1_slot_ff;
   logic          s1_expired_ff;
   tick_type      s1_cpu_ff;
   tick_type      s1_wall_ff;
   logic          byp_hit_ff;
   logic          byp_hit_in;
   stats_rec_type byp_rec_ff;
   logic [USED-1:0] used_ff;
   logic          rsp_valid_ff;
   stats_rec_type rsp_rec_ff;

   logic          req_ready;
   logic          req_accept;
   logic          s1_advance;
   logic          s1_in_range;
   logic [AW-1:0] s1_addr;
   logic          s1_update;
   logic          s1_clear;
   stats_rec_type ram_rdata;
   stats_rec_type old_rec;
   stats_rec_type new_rec;
   stats_rec_type res_rec;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_accept = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;

   assign s1_in_range = int'(s1_slot_ff) < SLOTS;
   assign s1_addr     = s1_slot_ff[AW-1:0];
   assign s1_clear    = (s1_kind_ff == KIND_CLEAR);
   assign s1_update   = (s1_kind_ff == KIND_UPDATE) && s1_in_range;

   // forward last write when the next beat hits the same slot (RAM reads old data)
   assign byp_hit_in = s1_advance && s1_update && (req_bus.slot_index == s1_slot_ff);

   pust_ram #(
      .WIDTH ($bits(stats_rec_type)),
      .DEPTH (USED)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_advance && s1_update),
      .wr_addr (s1_addr),
      .wr_data (new_rec),
      .rd_en   (req_accept),
      .rd_addr (req_bus.slot_index[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (!s1_in_range || !used_ff[s1_addr]) begin
         old_rec = EMPTY_REC;
      end else if (byp_hit_ff) begin
         old_rec = byp_rec_ff;
      end else begin
         old_rec = ram_rdata;
      end
   end

   pust_fold u_fold (
      .old_rec        (old_rec),
      .period_expired (s1_expired_ff),
      .cpu_ticks      (s1_cpu_ff),
      .wall_ticks     (s1_wall_ff),
      .new_rec        (new_rec)
   );

   always_comb begin
      if (s1_clear) begin
         res_rec = EMPTY_REC;
      end else if (s1_update) begin
         res_rec = new_rec;
      end else begin
         res_rec = old_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_hit_ff   <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
            byp_hit_ff  <= byp_hit_in;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance && s1_clear) begin
            used_ff <= '0;
         end else if (s1_advance && s1_update) begin
            used_ff[s1_addr] <= 1'b1;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff    <= req_bus.kind;
         s1_slot_ff    <= req_bus.slot_index;
         s1_expired_ff <= req_bus.period_expired;
         s1_cpu_ff     <= req_bus.cpu_ticks;
         s1_wall_ff    <= req_bus.wall_ticks;
         byp_rec_ff    <= new_rec;
      end
      if (s1_advance) begin
         rsp_rec_ff <= res_rec;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.period_count   = rsp_rec_ff.period_count;
   assign rsp_bus.missed_periods = rsp_rec_ff.missed_periods;
   assign rsp_bus.cpu_min        = rsp_rec_ff.cpu_min;
   assign rsp_bus.cpu_max        = rsp_rec_ff.cpu_max;
   assign rsp_bus.cpu_total      = rsp_rec_ff.cpu_total;
   assign rsp_bus.wall_min       = rsp_rec_ff.wall_min;
   assign rsp_bus.wall_max       = rsp_rec_ff.wall_max;
   assign rsp_bus.wall_total     = rsp_rec_ff.wall_total;

   `ASSERT_HOLDS(a_clear_drops_all, clock, reset,
                 s1_advance && s1_clear |=> used_ff == '0)
   `ASSERT_HOLDS(a_clear_gives_empty, clock, reset,
                 s1_advance && s1_clear |=> rsp_rec_ff == EMPTY_REC)
   `ASSERT_HOLDS(a_update_min_le_max, clock, reset,
                 s1_advance && s1_update |=>
                    rsp_rec_ff.cpu_min <= rsp_rec_ff.cpu_max &&
                    rsp_rec_ff.wall_min <= rsp_rec_ff.wall_max)
   `ASSERT_NEVER(a_stall_only_when_full, clock, reset,
                 !req_ready && !(s1_valid_ff && rsp_valid_ff && !rsp_bus.ready))

endmodule
